>>> rtl/dss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants of the delimiter stream splitter
// Transaction payloads, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package dss_pkg;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int DELIM_LEN_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 2'd1;

    // Default delimiter is CR LF
    localparam logic [CFG_DATA_W-1:0]  DELIM_BYTES_RST  = 64'h0000_0000_0000_0A0D;
    localparam logic [DELIM_LEN_W-1:0] DELIM_LENGTH_RST = 4'd2;

    // Input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       has_byte;
        logic       input_end;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       token_end;
        logic       empty_result;
        logic       run_last;
    } t_out_item;

    // Per-item control results of the split step
    typedef struct packed {
        logic held_valid;
        logic started;
        logic empty_result;
    } t_step_ctl;

endpackage
`default_nettype wire

>>> rtl/delimiter_stream_splitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delimiter_stream_splitter: streaming multi-byte delimiter split
// Splits a byte stream into tokens at every occurrence of a delimiter of up
// to MAX_DELIM_BYTES bytes and emits the token bytes one per transaction.
// ----------------------------------------------------------------------------
// An input transaction is taken into an input register; the split step then
// moves it into a result bundle of up to MAX_DELIM_BYTES+1 token bytes, which
// drains one output transaction per cycle while the receiver is ready. Plain
// token bytes thus flow at one byte per cycle unless the output stalls; an
// item that releases n bytes (a flush at string end, or bytes leaving the
// window after a failed partial match) holds the bundle until all n, up to
// MAX_DELIM_BYTES+1, have drained, and that drain sets the rate. The first
// result reaches the output via the input register and the result bundle.
// Configuration must be written while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module delimiter_stream_splitter #(
    parameter int MAX_DELIM_BYTES = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  dss_pkg::t_in_item                     i_in_item,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output dss_pkg::t_out_item                    o_out_item,
    input  wire logic                             i_cfg_we,
    input  wire logic [dss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dss_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import dss_pkg::*;

    localparam int WB = 8*MAX_DELIM_BYTES;
    localparam int FW = $clog2(MAX_DELIM_BYTES+1);
    localparam int CW = $clog2(MAX_DELIM_BYTES+2);
    localparam int BB = 8*(MAX_DELIM_BYTES+1);

    // configuration
    logic [CFG_DATA_W-1:0]  r_delim;
    logic [DELIM_LEN_W-1:0] r_delim_len;

    // input register
    logic     r_in_valid;
    t_in_item r_in_item;

    // split state
    logic [WB-1:0] r_window;
    logic [FW-1:0] r_fill;
    logic [7:0]    r_held_byte;
    logic          r_held_valid;
    logic          r_started;

    // result bundle
    logic [BB-1:0]            r_bytes;
    logic [MAX_DELIM_BYTES:0] r_ends;
    logic [CW-1:0]            r_cnt;
    logic                     r_empty;

    // step outputs
    logic [WB-1:0]            n_window;
    logic [FW-1:0]            n_fill;
    logic [7:0]               n_held_byte;
    t_step_ctl                n_ctl;
    logic [BB-1:0]            n_bytes;
    logic [MAX_DELIM_BYTES:0] n_ends;
    logic [CW-1:0]            n_cnt;

    logic in_fire;
    logic out_fire;
    logic bundle_free;
    logic load;

    // Handshakes
    assign out_fire    = o_out_valid && i_out_ready;
    assign bundle_free = (r_cnt == '0) || ((r_cnt == CW'(1)) && i_out_ready);
    assign load        = r_in_valid && bundle_free;
    assign o_in_ready  = !r_in_valid || load;
    assign in_fire     = i_in_valid && o_in_ready;

    // Output transaction from the head of the bundle
    assign o_out_valid             = (r_cnt != '0);
    assign o_out_item.out_byte     = r_bytes[7:0];
    assign o_out_item.token_end    = r_ends[0];
    assign o_out_item.empty_result = r_empty;
    assign o_out_item.run_last     = (r_cnt == CW'(1));

    // Split step
    dss_step #(
        .MAX_DELIM_BYTES (MAX_DELIM_BYTES)
    ) u_step (
        .i_item       (r_in_item),
        .i_window     (r_window),
        .i_fill       (r_fill),
        .i_held_byte  (r_held_byte),
        .i_held_valid (r_held_valid),
        .i_started    (r_started),
        .i_delim      (r_delim[WB-1:0]),
        .i_delim_len  (r_delim_len),
        .o_window     (n_window),
        .o_fill       (n_fill),
        .o_held_byte  (n_held_byte),
        .o_ctl        (n_ctl),
        .o_bytes      (n_bytes),
        .o_ends       (n_ends),
        .o_count      (n_cnt)
    );

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim      <= DELIM_BYTES_RST;
            r_delim_len  <= DELIM_LENGTH_RST;
            r_in_valid   <= 1'b0;
            r_window     <= '0;
            r_fill       <= '0;
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_started    <= 1'b0;
            r_cnt        <= '0;
            r_empty      <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DELIM_BYTES: begin
                        r_delim <= i_cfg_wdata;
                    end
                    CFG_DELIM_LENGTH: begin
                        r_delim_len <= i_cfg_wdata[DELIM_LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // input register occupancy
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end

            // split state and bundle count
            if (load) begin
                r_window     <= n_window;
                r_fill       <= n_fill;
                r_held_byte  <= n_held_byte;
                r_held_valid <= n_ctl.held_valid;
                r_started    <= n_ctl.started;
                r_cnt        <= n_cnt;
                r_empty      <= n_ctl.empty_result;
            end else if (out_fire) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_item <= i_in_item;
        end
        if (load) begin
            r_bytes <= n_bytes;
            r_ends  <= n_ends;
        end else if (out_fire) begin
            r_bytes <= r_bytes >> 8;
            r_ends  <= r_ends >> 1;
        end
    end

    // Checks
    a_empty_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_empty |-> r_cnt == CW'(1))
        else $error("empty token shares its bundle with other results");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FW'(MAX_DELIM_BYTES))
        else $error("match window holds a full delimiter");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_in_item.input_end |=> (r_fill == '0) && !r_held_valid && !r_started)
        else $error("string end left pending bytes");

    a_bundle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> r_cnt == $past(r_cnt))
        else $error("stalled bundle was overwritten");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && (r_cnt == CW'(1)) && !load |=> !o_out_valid)
        else $error("result shown after the last one was taken");

endmodule
`default_nettype wire

>>> rtl/dss_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dss_step: split step for one input item
// Appends the byte to the match window, finds the longest window suffix
// that is still a delimiter prefix, and builds the ordered list of token
// bytes released by the item together with the next window and held byte.
// ----------------------------------------------------------------------------
module dss_step #(
    parameter int MAX_DELIM_BYTES = 8
) (
    input  dss_pkg::t_in_item                         i_item,
    input  wire logic [8*MAX_DELIM_BYTES-1:0]         i_window,
    input  wire logic [$clog2(MAX_DELIM_BYTES+1)-1:0] i_fill,
    input  wire logic [7:0]                           i_held_byte,
    input  wire logic                                 i_held_valid,
    input  wire logic                                 i_started,
    input  wire logic [8*MAX_DELIM_BYTES-1:0]         i_delim,
    input  wire logic [dss_pkg::DELIM_LEN_W-1:0]      i_delim_len,
    output logic [8*MAX_DELIM_BYTES-1:0]              o_window,
    output logic [$clog2(MAX_DELIM_BYTES+1)-1:0]      o_fill,
    output logic [7:0]                                o_held_byte,
    output dss_pkg::t_step_ctl                        o_ctl,
    output logic [8*(MAX_DELIM_BYTES+1)-1:0]          o_bytes,
    output logic [MAX_DELIM_BYTES:0]                  o_ends,
    output logic [$clog2(MAX_DELIM_BYTES+2)-1:0]      o_count
);
    import dss_pkg::*;

    localparam int WB = 8*MAX_DELIM_BYTES;
    localparam int FW = $clog2(MAX_DELIM_BYTES+1);
    localparam int CW = $clog2(MAX_DELIM_BYTES+2);
    localparam int BB = 8*(MAX_DELIM_BYTES+1);

    logic                     has;
    logic                     fin;
    logic [FW-1:0]            s_fill;
    logic [FW-1:0]            act_len;
    logic [FW-1:0]            k_sel;
    logic [FW-1:0]            m_len;
    logic [WB-1:0]            seq;
    logic [MAX_DELIM_BYTES:0] cand;
    logic                     close_hit;
    logic                     empty_in;
    logic [CW-1:0]            b_len;
    logic [CW-1:0]            cnt;
    logic [BB-1:0]            b_list;

    assign has = i_item.has_byte;
    assign fin = i_item.input_end;

    // Window with the new byte appended
    assign s_fill = i_fill + FW'(has);
    assign seq    = has ? (i_window | (WB'(i_item.in_byte) << {i_fill, 3'b000})) : i_window;

    // Length in use, clamped to the window size
    always_comb begin
        if (i_delim_len > DELIM_LEN_W'(MAX_DELIM_BYTES)) begin
            act_len = FW'(MAX_DELIM_BYTES);
        end else begin
            act_len = FW'(i_delim_len);
        end
    end

    // Candidate cut points: suffix starting at kk matches a delimiter prefix
    always_comb begin
        for (int kk = 0; kk <= MAX_DELIM_BYTES; kk++) begin
            cand[kk] = (kk <= int'(s_fill)) && ((int'(s_fill) - kk) <= int'(act_len));
            for (int j = 0; j < MAX_DELIM_BYTES - kk; j++) begin
                if ((j + kk < int'(s_fill)) &&
                    (seq[8*(j+kk) +: 8] != i_delim[8*j +: 8])) begin
                    cand[kk] = 1'b0;
                end
            end
        end
    end

    // Leftmost cut point; the empty suffix always qualifies
    always_comb begin
        k_sel = s_fill;
        if (has) begin
            for (int kk = MAX_DELIM_BYTES; kk >= 0; kk--) begin
                if (cand[kk]) begin
                    k_sel = FW'(kk);
                end
            end
        end
    end

    assign m_len     = s_fill - k_sel;
    assign close_hit = has && (m_len == act_len) && (m_len != '0);
    assign empty_in  = fin && !has && !i_started;

    // Released byte list: held byte first, then bytes cut off the window
    assign b_list = i_held_valid ? {seq, i_held_byte} : {8'h00, seq};
    assign b_len  = CW'(i_held_valid) +
                    ((fin && !close_hit) ? CW'(s_fill) : CW'(k_sel));

    // Bytes that leave now; without a token end the last one stays held
    always_comb begin
        if (empty_in) begin
            cnt = CW'(1);
        end else if (!has && !fin) begin
            cnt = '0;
        end else if (fin || close_hit) begin
            cnt = b_len;
        end else if (b_len != '0) begin
            cnt = b_len - CW'(1);
        end else begin
            cnt = '0;
        end
    end

    assign o_count = cnt;

    // Next state and result flags
    always_comb begin
        o_bytes          = b_list;
        o_ends           = '0;
        o_window         = i_window;
        o_fill           = i_fill;
        o_held_byte      = i_held_byte;
        o_ctl.held_valid   = i_held_valid;
        o_ctl.started      = i_started;
        o_ctl.empty_result = 1'b0;
        if (empty_in) begin
            // empty string: one empty token
            o_bytes            = '0;
            o_ends             = (MAX_DELIM_BYTES+1)'(1);
            o_ctl.empty_result = 1'b1;
            o_window           = '0;
            o_fill             = '0;
            o_held_byte        = '0;
            o_ctl.held_valid   = 1'b0;
            o_ctl.started      = 1'b0;
        end else if (has || fin) begin
            for (int i = 0; i <= MAX_DELIM_BYTES; i++) begin
                o_ends[i] = (close_hit && (CW'(i+1) == CW'(i_held_valid) + CW'(k_sel))) ||
                            (fin && (CW'(i+1) == cnt));
            end
            if (fin || close_hit) begin
                o_window         = '0;
                o_fill           = '0;
                o_held_byte      = '0;
                o_ctl.held_valid = 1'b0;
            end else begin
                o_window         = seq >> {k_sel, 3'b000};
                o_fill           = m_len;
                o_ctl.held_valid = (b_len != '0);
                for (int i = 0; i <= MAX_DELIM_BYTES; i++) begin
                    if (CW'(i+1) == b_len) begin
                        o_held_byte = b_list[8*i +: 8];
                    end
                end
            end
            o_ctl.started = !fin;
        end
    end

endmodule
`default_nettype wire

>>> dv/delimiter_stream_splitter_tb.sv
// ----------------------------------------------------------------------------
// delimiter_stream_splitter_tb: self-checking bench for the delimiter splitter
// Feeds byte strings through the input channel, predicts every token byte the
// splitter must emit with a cycle-free model of the split, and checks each
// output transaction against the oldest prediction. A short directed table
// comes first, then random strings built from tokens, delimiters and broken
// delimiter prefixes under a series of delimiter settings.
// ----------------------------------------------------------------------------
module delimiter_stream_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dss_pkg::*;

    localparam int MAX_DELIM   = 8;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYC  = 12;   // input register plus a full bundle drain, with margin
    localparam int PHASE_ITEMS = 33;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;
    // how a directed row is checked: by the predictor, by a typed result, or not at all
    typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_ONE} t_chk_kind;

    typedef struct {
        t_row_kind    kind;
        t_in_item     item;
        t_chk_kind    chk;
        t_out_item    typed;
        logic [63:0]  delim;
        logic [3:0]   dlen;
    } t_stim_row;

    // DUT ports; the driven inputs are known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Split model state and its copy of the registers
    logic [63:0] win;
    logic [3:0]  fill;
    logic [7:0]  held;
    bit          held_v;
    bit          started;
    logic [63:0] m_delim;
    logic [3:0]  m_len;

    t_out_item   step_out[$];     // results of the item being predicted
    t_out_item   tokens_due[$];   // predicted output transactions not yet seen
    t_stim_row   dir_rows[$];

    int fault_count = 0;
    int burst_left  = 0;
    bit steady      = 1'b0;

    delimiter_stream_splitter #(
        .MAX_DELIM_BYTES(MAX_DELIM)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Split predictor
    // ------------------------------------------------------------------
    function automatic void emit(logic [7:0] b, bit te, bit em);
        t_out_item r;
        if (step_out.size() < MAX_DELIM + 1) begin
            r.out_byte     = b;
            r.token_end    = te;
            r.empty_result = em;
            r.run_last     = 1'b0;
            step_out = {step_out, r};
        end
    endfunction

    // new byte joins the token, previously held byte leaves unmarked
    function automatic void push_token_byte(logic [7:0] b);
        if (held_v) emit(held, 1'b0, 1'b0);
        held   = b;
        held_v = 1'b1;
    endfunction

    function automatic void close_token();
        if (held_v) emit(held, 1'b1, 1'b0);
        held_v = 1'b0;
        held   = '0;
    endfunction

    function automatic void shift_window();
        push_token_byte(win[7:0]);
        win  = win >> 8;
        fill = fill - 4'd1;
    endfunction

    function automatic logic [63:0] lane_mask(int n);
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic void take_byte(logic [7:0] b);
        int          len;
        logic [63:0] m;
        bit          same;
        bit          busy;
        len = (m_len > 4'd8) ? 8 : int'(m_len);
        if (fill >= 4'd8) shift_window();
        win  = win | ({56'd0, b} << (8 * int'(fill)));
        fill = fill + 4'd1;
        busy = 1'b1;
        // drop oldest pending bytes until the window is a delimiter prefix
        while (busy) begin
            m    = lane_mask(int'(fill));
            same = ((win & m) == (m_delim & m));
            if (fill != 4'd0 && int'(fill) == len && same) begin
                win  = '0;
                fill = '0;
                close_token();
                busy = 1'b0;
            end else if (int'(fill) <= len && same) begin
                busy = 1'b0;
            end else begin
                shift_window();
            end
        end
    endfunction

    function automatic void split_step(t_in_item it);
        step_out.delete();
        if (it.has_byte) begin
            started = 1'b1;
            take_byte(it.in_byte);
        end
        if (it.input_end) begin
            if (!started) begin
                emit(8'h00, 1'b1, 1'b1);
            end else begin
                while (fill > 4'd0) shift_window();
                close_token();
            end
            win     = '0;
            fill    = '0;
            held_v  = 1'b0;
            held    = '0;
            started = 1'b0;
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].run_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Output checker
    // ------------------------------------------------------------------
    function automatic void note_failure(string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin : out_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tokens_due.size() == 0) begin
                note_failure($sformatf("unexpected output transaction %h", o_out_item));
            end else begin
                want = tokens_due.pop_front();
                if (o_out_item.out_byte !== want.out_byte ||
                    o_out_item.token_end !== want.token_end ||
                    o_out_item.empty_result !== want.empty_result ||
                    o_out_item.run_last !== want.run_last)
                    note_failure($sformatf(
                        "mismatch exp/got: byte %h/%h tok_end %b/%b empty %b/%b last %b/%b",
                        want.out_byte, o_out_item.out_byte,
                        want.token_end, o_out_item.token_end,
                        want.empty_result, o_out_item.empty_result,
                        want.run_last, o_out_item.run_last));
            end
        end
    end

    // Receiver: stall pattern that switches between random modes
    int          rx_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_cnt  = 0;
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(32, 256);
        end
        rx_left--;
        rx_cnt++;
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= ($urandom_range(0, 7) != 0);
            default: i_out_ready <= ((rx_cnt % 7) >= 3);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // one input transaction, preceded at burst boundaries by a random gap unless steady
    task automatic send_item(t_in_item it, t_chk_kind chk = CHK_PRED,
                             t_out_item typed = '0);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        split_step(it);
        case (chk)
            CHK_PRED: tokens_due = {tokens_due, step_out};
            CHK_ONE:  tokens_due = {tokens_due, typed};
            default: ;
        endcase
    endtask

    // stop sending and let every predicted transaction come out
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic set_delimiter(logic [63:0] bytes, logic [3:0] len);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DELIM_BYTES;
        i_cfg_wdata <= bytes;
        @(posedge i_clk);
        m_delim = bytes;
        i_cfg_index <= CFG_DELIM_LENGTH;
        i_cfg_wdata <= {60'd0, len};
        @(posedge i_clk);
        m_len = len;
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item mk_in(logic [7:0] b, bit has, bit fin);
        t_in_item it;
        it.in_byte   = b;
        it.has_byte  = has;
        it.input_end = fin;
        return it;
    endfunction

    // single typed result, always the last of its item
    function automatic t_out_item tok(logic [7:0] b, bit te, bit em);
        t_out_item r;
        r.out_byte     = b;
        r.token_end    = te;
        r.empty_result = em;
        r.run_last     = 1'b1;
        return r;
    endfunction

    function automatic void row_in(logic [7:0] b, bit has, bit fin,
                                   t_chk_kind chk = CHK_PRED, t_out_item typed = '0);
        t_stim_row r;
        r.kind  = ROW_ITEM;
        r.item  = mk_in(b, has, fin);
        r.chk   = chk;
        r.typed = typed;
        r.delim = '0;
        r.dlen  = '0;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void row_cfg(logic [63:0] bytes, logic [3:0] len);
        t_stim_row r;
        r.kind  = ROW_CFG;
        r.item  = '0;
        r.chk   = CHK_NONE;
        r.typed = '0;
        r.delim = bytes;
        r.dlen  = len;
        dir_rows = {dir_rows, r};
    endfunction

    // Directed stimulus, reset delimiter is CR LF
    function automatic void load_directed();
        row_in(8'h00, 1'b0, 1'b1, CHK_ONE, tok(8'h00, 1'b1, 1'b1));  // empty string
        row_in(8'hFF, 1'b1, 1'b1, CHK_ONE, tok(8'hFF, 1'b1, 1'b0));
        row_in(8'h00, 1'b1, 1'b1, CHK_ONE, tok(8'h00, 1'b1, 1'b0));
        row_in(8'h61, 1'b1, 1'b0);
        row_in(8'h0D, 1'b1, 1'b0);
        row_in(8'h0A, 1'b1, 1'b0);
        row_in(8'h62, 1'b1, 1'b1);
        row_in(8'h0D, 1'b1, 1'b0, CHK_NONE);                       // delimiters only
        row_in(8'h0A, 1'b1, 1'b1, CHK_NONE);
        row_in(8'h5A, 1'b0, 1'b0, CHK_NONE);                       // ignored item
        row_in(8'h0D, 1'b1, 1'b0);                                 // broken prefix
        row_in(8'h0D, 1'b1, 1'b0);
        row_in(8'h41, 1'b1, 1'b1);
        row_cfg(64'h0A0D, 4'd0);                                   // no splitting
        row_in(8'h0D, 1'b1, 1'b0);
        row_in(8'h0A, 1'b1, 1'b0);
        row_in(8'h33, 1'b1, 1'b1);
        row_cfg('1, 4'd15);                                        // length clamps to 8
        row_in(8'hFF, 1'b1, 1'b0);
        row_in(8'hFF, 1'b1, 1'b0);
        row_in(8'hFF, 1'b1, 1'b0);
        row_in(8'h00, 1'b1, 1'b1);
        row_in(8'hFF, 1'b1, 1'b0);
        row_in(8'hFF, 1'b1, 1'b0);
        row_cfg(64'h2C, 4'd1);                                     // change mid-string
        row_in(8'h2C, 1'b1, 1'b1);
        row_in(8'h00, 1'b0, 1'b1, CHK_ONE, tok(8'h00, 1'b1, 1'b1));
    endfunction

    function automatic logic [7:0] pick_byte(bit narrow);
        if (!narrow) return 8'($urandom);
        if ($urandom_range(0, 1)) return m_delim[8*$urandom_range(0, 7) +: 8];
        return 8'h41 + 8'($urandom_range(0, 3));
    endfunction

    // One delimiter setting, then random strings until the item goal is met
    task automatic run_phase(logic [3:0] len);
        logic [63:0] bytes;
        logic [7:0]  str[$];
        int          dl;
        int          count;
        int          n;
        int          r;
        bit          narrow;
        bit          end_on_byte;
        case ($urandom_range(0, 4))
            0: bytes = {$urandom, $urandom};
            1: bytes = '1;
            2: bytes = '0;
            default:
                for (int k = 0; k < 8; k++) bytes[8*k +: 8] = 8'h41 + 8'($urandom_range(0, 3));
        endcase
        hold_until_drained();
        set_delimiter(bytes, len);
        dl     = (len > 4'd8) ? 8 : int'(len);
        narrow = $urandom_range(0, 2) != 0;
        steady = $urandom_range(0, 3) == 0;
        count  = 0;
        while (count < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_item(mk_in(8'($urandom), 1'b0, 1'b0));        // noise, ignored
            end else if (r < 10) begin
                send_item(mk_in(8'($urandom), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1))));
                count++;
            end else if (r < 14) begin
                send_item(mk_in(8'($urandom), 1'b0, 1'b1));
                count++;
            end else begin
                // string of tokens, delimiters and broken delimiter prefixes
                str.delete();
                repeat ($urandom_range(1, 5)) begin
                    case ($urandom_range(0, 3))
                        2: for (int k = 0; k < dl; k++) str = {str, m_delim[8*k +: 8]};
                        3: if (dl >= 2) begin
                            n = $urandom_range(1, dl - 1);
                            for (int k = 0; k < n; k++) str = {str, m_delim[8*k +: 8]};
                            str = {str, pick_byte(narrow)};
                        end
                        default: repeat ($urandom_range(1, 6)) str = {str, pick_byte(narrow)};
                    endcase
                end
                end_on_byte = (str.size() > 0) && $urandom_range(0, 1);
                foreach (str[k])
                    send_item(mk_in(str[k], 1'b1, end_on_byte && (k == str.size() - 1)));
                if (!end_on_byte) send_item(mk_in(8'($urandom), 1'b0, 1'b1));
                count += str.size() + (end_on_byte ? 0 : 1);
                if ($urandom_range(0, 9) == 0) hold_until_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [3:0] len_plan[10];
        len_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd9, 4'd5, 4'd4, 4'd8};
        win     = '0;
        fill    = '0;
        held    = '0;
        held_v  = 1'b0;
        started = 1'b0;
        m_delim = DELIM_BYTES_RST;
        m_len   = DELIM_LENGTH_RST;
        load_directed();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                hold_until_drained();
                set_delimiter(dir_rows[k].delim, dir_rows[k].dlen);
            end else begin
                send_item(dir_rows[k].item, dir_rows[k].chk, dir_rows[k].typed);
            end
        end

        for (int p = 0; p < 10; p++) begin
            if (p >= 6 && $urandom_range(0, 1)) run_phase(4'($urandom_range(0, 15)));
            else run_phase(len_plan[p]);
        end

        hold_until_drained();
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/dss_pkg.sv
rtl/dss_step.sv
rtl/delimiter_stream_splitter.sv
dv/delimiter_stream_splitter_tb.sv
